### hdl/resc_pkg.sv
// ----------------------------------------------------------------------------
// ROI edge side checker package
// Field widths, word layout, state codes and derived datapath widths.
// ----------------------------------------------------------------------------
package resc_pkg;

   // Field widths.
   localparam int COORD_BITS  = 16;
   localparam int FRAC_BITS   = 16;
   localparam int STATE_BITS  = 3;
   localparam int FLAG_BITS   = 4;
   localparam int SLOPE_BITS  = 24;
   localparam int OFFSET_BITS = 32;
   localparam int SIZE_BITS   = 15;
   localparam int WIDTH_BITS  = 16;

   localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = WIDTH_BITS'(1024);

   // Request word layout, lowest bits first.
   localparam int OFS_FLAGS = 0;
   localparam int OFS_LM    = OFS_FLAGS + FLAG_BITS;
   localparam int OFS_LQ    = OFS_LM + SLOPE_BITS;
   localparam int OFS_RM    = OFS_LQ + OFFSET_BITS;
   localparam int OFS_RQ    = OFS_RM + SLOPE_BITS;
   localparam int OFS_SX    = OFS_RQ + OFFSET_BITS;
   localparam int OFS_SY    = OFS_SX + COORD_BITS;
   localparam int OFS_X     = OFS_SY + COORD_BITS;
   localparam int OFS_Y     = OFS_X + COORD_BITS;
   localparam int OFS_W     = OFS_Y + COORD_BITS;
   localparam int OFS_H     = OFS_W + SIZE_BITS;
   localparam int REQ_RAW_BITS  = OFS_H + SIZE_BITS;
   localparam int REQ_DATA_BITS = ((REQ_RAW_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 8;

   // Datapath widths.
   localparam int XE_BITS  = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 1;
   localparam int C2A_BITS = (XE_BITS + 1 > WIDTH_BITS + 1) ? XE_BITS + 1 : WIDTH_BITS + 1;
   localparam int C2_BITS  = C2A_BITS + 1;
   localparam int LP_BITS  = SLOPE_BITS + COORD_BITS;
   localparam int LY_BITS  = ((LP_BITS > OFFSET_BITS) ? LP_BITS : OFFSET_BITS) + 1;
   localparam int CX_BITS  = XE_BITS + 1;
   localparam int CY_BITS  = XE_BITS + 1;
   localparam int MP_BITS  = SLOPE_BITS + CX_BITS;
   localparam int DF_BITS  = ((CY_BITS + FRAC_BITS > OFFSET_BITS) ?
                              CY_BITS + FRAC_BITS : OFFSET_BITS) + 1;
   localparam int FC_BITS  = (MP_BITS > DF_BITS) ? MP_BITS : DF_BITS;

   typedef enum logic [STATE_BITS-1:0] {
      ST_MATERIAL   = 3'd0,
      ST_BACKGROUND = 3'd1,
      ST_UNKNOWN    = 3'd2,
      ST_INVALID    = 3'd3,
      ST_LEFT_EDGE  = 3'd4,
      ST_RIGHT_EDGE = 3'd5,
      ST_BOTH_EDGES = 3'd6,
      ST_OTHER      = 3'd7
   } image_state_type;

   typedef enum logic [1:0] {
      LINE_LEFT,
      LINE_RIGHT,
      LINE_ZERO,
      LINE_COMPARE
   } line_sel_type;

endpackage

### hdl/roi_edge_side_checker.sv
// ----------------------------------------------------------------------------
// ROI edge side checker
// Picks an edge line for one edge record and tells whether the ROI lies
// fully on the material blank.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Word
//  req_*     in   tuser: image_state; tdata: edge record (see port comment)
//  rsp_*     out  tdata: on_blank in bit 0
//  csr_*     in   image_width write, no read-back
//
// Five register stages: products at x0, line values, line pick, corner
// product, final compare into the output register. rsp_tvalid rises when the
// word reaches the output register; one word per cycle is taken when not stalled.
// All stages advance together; while rsp_tvalid is high and rsp_tready low,
// req_tready is low and every stage holds. Synchronous reset clears the
// valid bits and sets image_width to 1024.
//
module roi_edge_side_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [resc_pkg::WIDTH_BITS-1:0]       csr_wr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: side_flags, left_slope, left_offset, right_slope,
   // right_offset, info_shift_x, info_shift_y, roi_x, roi_y, roi_width,
   // roi_height, zero fill.
   input  logic [resc_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // Fields from bit 0: image_state.
   input  logic [resc_pkg::STATE_BITS-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0: on_blank, zero fill.
   output logic [resc_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);
   import resc_pkg::*;

   logic                  en;
   logic [WIDTH_BITS-1:0] width_ff;

   // Request fields.
   logic [FLAG_BITS-1:0]          req_flags;
   logic signed [SLOPE_BITS-1:0]  req_lm, req_rm;
   logic signed [OFFSET_BITS-1:0] req_lq, req_rq;
   logic signed [COORD_BITS-1:0]  req_sx, req_sy, req_x0, req_y0;
   logic [SIZE_BITS-1:0]          req_w, req_h;

   // Stage 1.
   logic                          v1_ff;
   image_state_type               st1_ff, st1_in;
   logic [FLAG_BITS-1:0]          fl1_ff;
   logic signed [SLOPE_BITS-1:0]  lm1_ff, rm1_ff;
   logic signed [OFFSET_BITS-1:0] lq1_ff, rq1_ff;
   logic signed [LP_BITS-1:0]     pl1_ff, pl1_in, pr1_ff, pr1_in;
   logic                          gt1_ff, gt1_in, lt1_ff, lt1_in;
   logic signed [XE_BITS-1:0]     x01_ff, x11_ff, x11_in, y01_ff, y11_ff, y11_in;
   logic signed [COORD_BITS-1:0]  sx1_ff, sy1_ff;
   logic signed [C2_BITS-1:0]     c2, x0d, x1d;

   // Stage 2.
   logic                          v2_ff;
   logic                          fix2_ff, fix2_in, fv2_ff, fv2_in;
   line_sel_type                  ls2_ff, ls2_in;
   logic                          tm2_ff, tm2_in;
   logic signed [LY_BITS-1:0]     yl2_ff, yl2_in, yr2_ff, yr2_in;
   logic signed [SLOPE_BITS-1:0]  lm2_ff, rm2_ff;
   logic signed [OFFSET_BITS-1:0] lq2_ff, rq2_ff;
   logic signed [CX_BITS-1:0]     cx02_ff, cx02_in, cx12_ff, cx12_in;
   logic signed [CY_BITS-1:0]     cy2_ff, cy2_in;
   logic                          full_bg, full_mat;

   // Stage 3.
   logic                          v3_ff;
   logic                          fix3_ff, fv3_ff, tm3_ff;
   logic signed [SLOPE_BITS-1:0]  m3_ff, m3_in;
   logic signed [OFFSET_BITS-1:0] q3_ff, q3_in;
   logic signed [CX_BITS-1:0]     cx3_ff, cx3_in;
   logic signed [CY_BITS-1:0]     cy3_ff;
   logic                          pick_right;

   // Stage 4.
   logic                          v4_ff;
   logic                          fix4_ff, fv4_ff, tm4_ff;
   logic signed [MP_BITS-1:0]     mp4_ff, mp4_in;
   logic signed [DF_BITS-1:0]     df4_ff, df4_in;

   // Stage 5, output register.
   logic                          v5_ff;
   logic                          ob5_ff, ob5_in;
   logic signed [FC_BITS-1:0]     prod_ext, diff_ext;

   assign en         = !v5_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS-1)'(0), ob5_ff};

   assign req_flags = req_tdata[OFS_FLAGS +: FLAG_BITS];
   assign req_lm    = $signed(req_tdata[OFS_LM +: SLOPE_BITS]);
   assign req_lq    = $signed(req_tdata[OFS_LQ +: OFFSET_BITS]);
   assign req_rm    = $signed(req_tdata[OFS_RM +: SLOPE_BITS]);
   assign req_rq    = $signed(req_tdata[OFS_RQ +: OFFSET_BITS]);
   assign req_sx    = $signed(req_tdata[OFS_SX +: COORD_BITS]);
   assign req_sy    = $signed(req_tdata[OFS_SY +: COORD_BITS]);
   assign req_x0    = $signed(req_tdata[OFS_X +: COORD_BITS]);
   assign req_y0    = $signed(req_tdata[OFS_Y +: COORD_BITS]);
   assign req_w     = req_tdata[OFS_W +: SIZE_BITS];
   assign req_h     = req_tdata[OFS_H +: SIZE_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= IMAGE_WIDTH_RESET;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   // ---------------- Stage 1: products at roi_x, centre tests ----------------
   always_comb begin
      st1_in = image_state_type'(req_tuser);
      x11_in = XE_BITS'(req_x0) + XE_BITS'($signed({1'b0, req_w}));
      y11_in = XE_BITS'(req_y0) + XE_BITS'($signed({1'b0, req_h}));
      c2     = (C2_BITS'(req_sx) <<< 1) + $signed(C2_BITS'(width_ff));
      x0d    = C2_BITS'(req_x0) <<< 1;
      x1d    = C2_BITS'(x11_in) <<< 1;
      gt1_in = x0d > c2;
      lt1_in = x1d < c2;
      pl1_in = LP_BITS'(req_lm) * LP_BITS'(req_x0);
      pr1_in = LP_BITS'(req_rm) * LP_BITS'(req_x0);
   end

   // ---------------- Stage 2: line values, line and side choice --------------
   always_comb begin
      full_bg  = fl1_ff[0] && fl1_ff[1];
      full_mat = fl1_ff[2] && fl1_ff[3];
      fix2_in  = 1'b0;
      fv2_in   = 1'b0;
      ls2_in   = LINE_ZERO;
      tm2_in   = !fl1_ff[0];
      unique case (st1_ff)
         ST_MATERIAL: begin
            fix2_in = 1'b1;
            fv2_in  = 1'b1;
         end
         ST_BACKGROUND, ST_UNKNOWN, ST_INVALID: begin
            fix2_in = 1'b1;
         end
         ST_LEFT_EDGE: begin
            ls2_in = LINE_LEFT;
            if (full_bg) begin
               tm2_in = fl1_ff[2];
            end
            if (gt1_ff && (full_bg || full_mat)) begin
               ls2_in = LINE_ZERO;
               tm2_in = full_bg;
            end
         end
         ST_RIGHT_EDGE: begin
            ls2_in = LINE_RIGHT;
            if (full_bg) begin
               tm2_in = fl1_ff[2];
            end else if (lt1_ff && full_mat) begin
               ls2_in = LINE_ZERO;
               tm2_in = 1'b0;
            end
         end
         ST_BOTH_EDGES: begin
            priority if (lt1_ff) begin
               ls2_in = LINE_LEFT;
            end else if (gt1_ff) begin
               ls2_in = LINE_RIGHT;
            end else begin
               ls2_in = LINE_COMPARE;
            end
         end
         ST_OTHER: begin
            ls2_in = LINE_ZERO;
         end
         default: begin
            fix2_in = 1'b1;
         end
      endcase
      yl2_in  = LY_BITS'(pl1_ff) + LY_BITS'(lq1_ff);
      yr2_in  = LY_BITS'(pr1_ff) + LY_BITS'(rq1_ff);
      cx02_in = CX_BITS'(x01_ff) + CX_BITS'(sx1_ff);
      cx12_in = CX_BITS'(x11_ff) + CX_BITS'(sx1_ff);
      // Corner y with the frame offset already taken off.
      cy2_in  = (tm2_in ? CY_BITS'(y11_ff) : CY_BITS'(y01_ff)) - CY_BITS'(sy1_ff);
   end

   // ---------------- Stage 3: line pick and corner ---------------------------
   always_comb begin
      // On a tie the left line wins.
      pick_right = tm2_ff ? (yr2_ff < yl2_ff) : (yr2_ff > yl2_ff);
      m3_in = '0;
      q3_in = '0;
      unique case (ls2_ff)
         LINE_LEFT: begin
            m3_in = lm2_ff;
            q3_in = lq2_ff;
         end
         LINE_RIGHT: begin
            m3_in = rm2_ff;
            q3_in = rq2_ff;
         end
         LINE_COMPARE: begin
            m3_in = pick_right ? rm2_ff : lm2_ff;
            q3_in = pick_right ? rq2_ff : lq2_ff;
         end
         default: begin
            m3_in = '0;
            q3_in = '0;
         end
      endcase
      // The corner that meets the line first depends on slope sign and side.
      if ((m3_in > 0) == tm2_ff) begin
         cx3_in = cx02_ff;
      end else begin
         cx3_in = cx12_ff;
      end
   end

   // ---------------- Stage 4: line at corner, scaled corner y ----------------
   always_comb begin
      mp4_in = MP_BITS'(m3_ff) * MP_BITS'(cx3_ff);
      df4_in = (DF_BITS'(cy3_ff) <<< FRAC_BITS) - DF_BITS'(q3_ff);
   end

   // ---------------- Stage 5: side test --------------------------------------
   always_comb begin
      prod_ext = FC_BITS'(mp4_ff);
      diff_ext = FC_BITS'(df4_ff);
      if (fix4_ff) begin
         ob5_in = fv4_ff;
      end else if (tm4_ff) begin
         ob5_in = !(diff_ext > prod_ext);
      end else begin
         ob5_in = !(diff_ext < prod_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_ff  <= st1_in;
         fl1_ff  <= req_flags;
         lm1_ff  <= req_lm;
         lq1_ff  <= req_lq;
         rm1_ff  <= req_rm;
         rq1_ff  <= req_rq;
         pl1_ff  <= pl1_in;
         pr1_ff  <= pr1_in;
         gt1_ff  <= gt1_in;
         lt1_ff  <= lt1_in;
         x01_ff  <= XE_BITS'(req_x0);
         x11_ff  <= x11_in;
         y01_ff  <= XE_BITS'(req_y0);
         y11_ff  <= y11_in;
         sx1_ff  <= req_sx;
         sy1_ff  <= req_sy;

         fix2_ff <= fix2_in;
         fv2_ff  <= fv2_in;
         ls2_ff  <= ls2_in;
         tm2_ff  <= tm2_in;
         yl2_ff  <= yl2_in;
         yr2_ff  <= yr2_in;
         lm2_ff  <= lm1_ff;
         lq2_ff  <= lq1_ff;
         rm2_ff  <= rm1_ff;
         rq2_ff  <= rq1_ff;
         cx02_ff <= cx02_in;
         cx12_ff <= cx12_in;
         cy2_ff  <= cy2_in;

         fix3_ff <= fix2_ff;
         fv3_ff  <= fv2_ff;
         tm3_ff  <= tm2_ff;
         m3_ff   <= m3_in;
         q3_ff   <= q3_in;
         cx3_ff  <= cx3_in;
         cy3_ff  <= cy2_ff;

         fix4_ff <= fix3_ff;
         fv4_ff  <= fv3_ff;
         tm4_ff  <= tm3_ff;
         mp4_ff  <= mp4_in;
         df4_ff  <= df4_in;

         ob5_ff  <= ob5_in;
      end
   end

   // A waiting word blocks new input.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted while output word is stalled");

   // Fixed-state words come out with their fixed answer.
   a_fixed_result: assert property (@(posedge clock) disable iff (reset)
      (en && v4_ff && fix4_ff) |=> (rsp_tvalid && (rsp_tdata[0] == $past(fv4_ff))))
      else $error("fixed-state result lost or wrong");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ROI edge side checker testbench
// Sends edge records over the request stream and checks every on_blank word
// against an in-bench predictor of the edge pick and the corner test. A short
// directed part covers each image state, the centre split and the extremes;
// random records then run under several image widths and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
   import resc_pkg::*;

   localparam int     WATCHDOG_LIMIT = 5000;
   localparam longint SLOPE_MAX      = 64'sd8388607;
   localparam longint SLOPE_MIN      = -64'sd8388608;
   localparam longint OFFSET_MAX     = 64'sd2147483647;
   localparam longint OFFSET_MIN     = -64'sd2147483648;
   localparam longint ONE_PX         = 64'sd1 << FRAC_BITS;

   typedef struct {
      image_state_type              state;
      logic [FLAG_BITS-1:0]         flags;
      logic signed [SLOPE_BITS-1:0] lm;
      logic signed [OFFSET_BITS-1:0] lq;
      logic signed [SLOPE_BITS-1:0] rm;
      logic signed [OFFSET_BITS-1:0] rq;
      logic signed [COORD_BITS-1:0] sx;
      logic signed [COORD_BITS-1:0] sy;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [SIZE_BITS-1:0]         w;
      logic [SIZE_BITS-1:0]         h;
   } edge_record_type;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     csr_wr_en   = 1'b0;
   logic [WIDTH_BITS-1:0]    csr_wr_data = '0;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic [STATE_BITS-1:0]    req_tuser   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   logic [WIDTH_BITS-1:0] image_width_model = IMAGE_WIDTH_RESET;
   bit                    pending_on_blank[$];
   bit                    wanted_blank;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    failures      = 0;
   int                    results_seen  = 0;
   int                    blank_results = 0;
   int                    width_writes  = 0;
   int                    states_sent[8];
   int                    idle_cycles   = 0;

   roi_edge_side_checker uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Decides whether the ROI lies fully on the blank for one edge record.
   function automatic bit roi_on_blank(edge_record_type r, logic [WIDTH_BITS-1:0] iw);
      longint x0, y0, x1, y1, centre2, m, q, cx, cy, ly, yl, yr;
      bit     full_bg, full_mat, top_material;
      x0 = longint'(r.x);
      y0 = longint'(r.y);
      x1 = x0 + longint'(r.w);
      y1 = y0 + longint'(r.h);
      centre2 = 2 * longint'(r.sx) + longint'(iw);
      full_bg = r.flags[0] && r.flags[1];
      full_mat = r.flags[2] && r.flags[3];
      top_material = !r.flags[0];
      m = 0;
      q = 0;
      case (r.state)
         ST_MATERIAL: return 1'b1;
         ST_BACKGROUND, ST_UNKNOWN, ST_INVALID: return 1'b0;
         ST_LEFT_EDGE: begin
            m = r.lm;
            q = r.lq;
            if (full_bg) top_material = r.flags[2];
            // A left edge seen right of centre with a uniform record falls back
            // to the flat line.
            if (2 * x0 > centre2 && (full_bg || full_mat)) begin
               m = 0;
               q = 0;
               top_material = full_bg;
            end
         end
         ST_RIGHT_EDGE: begin
            m = r.rm;
            q = r.rq;
            if (full_bg) begin
               top_material = r.flags[2];
            end else if (2 * x1 < centre2 && full_mat) begin
               m = 0;
               q = 0;
               top_material = 1'b0;
            end
         end
         ST_BOTH_EDGES: begin
            if (2 * x1 < centre2) begin
               m = r.lm;
               q = r.lq;
            end else if (2 * x0 > centre2) begin
               m = r.rm;
               q = r.rq;
            end else begin
               // Across the centre: compare both lines at roi_x, ties go left.
               yl = longint'(r.lm) * x0 + longint'(r.lq);
               yr = longint'(r.rm) * x0 + longint'(r.rq);
               if (top_material ? (yr < yl) : (yr > yl)) begin
                  m = r.rm;
                  q = r.rq;
               end else begin
                  m = r.lm;
                  q = r.lq;
               end
            end
         end
         default: ;
      endcase
      q = q + longint'(r.sy) * ONE_PX;
      if (top_material) cx = (m > 0) ? x0 : x1;
      else cx = (m > 0) ? x1 : x0;
      cx = cx + longint'(r.sx);
      cy = (top_material ? y1 : y0) * ONE_PX;
      ly = m * cx + q;
      return !((top_material && cy > ly) || (!top_material && cy < ly));
   endfunction

   function automatic edge_record_type make_record(image_state_type state, longint flags,
         longint lm, longint lq, longint rm, longint rq, longint sx, longint sy,
         longint x, longint y, longint w, longint h);
      edge_record_type r;
      r.state = state;
      r.flags = FLAG_BITS'(flags);
      r.lm = SLOPE_BITS'(lm);
      r.lq = OFFSET_BITS'(lq);
      r.rm = SLOPE_BITS'(rm);
      r.rq = OFFSET_BITS'(rq);
      r.sx = COORD_BITS'(sx);
      r.sy = COORD_BITS'(sy);
      r.x = COORD_BITS'(x);
      r.y = COORD_BITS'(y);
      r.w = SIZE_BITS'(w);
      r.h = SIZE_BITS'(h);
      return r;
   endfunction

   function automatic longint rand_span(longint lo, longint hi);
      return lo + longint'($urandom_range(32'(hi - lo)));
   endfunction

   function automatic longint rand_slope();
      case ($urandom_range(5))
         0: return 0;
         1: return rand_span(SLOPE_MIN, SLOPE_MAX);
         default: return rand_span(-131072, 131072);
      endcase
   endfunction

   // Intercept that puts the line within h + 50 rows of roi_y.
   function automatic longint near_offset(longint m, longint x, longint y, longint sy,
         longint h);
      return (y + rand_span(-h - 50, h + 50) - sy) * ONE_PX - m * x + rand_span(0, 65535);
   endfunction

   function automatic edge_record_type random_record(logic [WIDTH_BITS-1:0] iw);
      edge_record_type r;
      longint          sx, sy, half, x, y, w, h, lm, rm, lq, rq;
      r.state = ($urandom_range(99) < 12) ? image_state_type'($urandom_range(3)) :
                                            image_state_type'($urandom_range(7, 4));
      r.flags = FLAG_BITS'($urandom_range(15));
      if ($urandom_range(9) == 0) begin
         r.lm = SLOPE_BITS'($urandom);
         r.lq = OFFSET_BITS'($urandom);
         r.rm = SLOPE_BITS'($urandom);
         r.rq = OFFSET_BITS'($urandom);
         r.sx = COORD_BITS'($urandom);
         r.sy = COORD_BITS'($urandom);
         r.x = COORD_BITS'($urandom);
         r.y = COORD_BITS'($urandom);
         r.w = SIZE_BITS'($urandom);
         r.h = SIZE_BITS'($urandom);
         return r;
      end
      sx = rand_span(-100, 100);
      sy = rand_span(-100, 100);
      half = longint'(iw) / 2;
      w = ($urandom_range(9) == 0) ? longint'($urandom_range(32767)) :
                                     longint'($urandom_range(300));
      h = ($urandom_range(9) == 0) ? longint'($urandom_range(32767)) :
                                     longint'($urandom_range(300));
      case ($urandom_range(4))
         0: x = sx + half - w - rand_span(1, 200);
         1: x = sx + half + rand_span(1, 200);
         2: x = sx + half - rand_span(0, w);
         // Either roi_x or the ROI end lands on the centre (rounded down for an odd width).
         3: x = ($urandom_range(1) == 0) ? sx + half : sx + half - w;
         default: x = rand_span(-32768, 32767);
      endcase
      y = rand_span(-500, 500);
      lm = rand_slope();
      rm = rand_slope();
      lq = ($urandom_range(5) == 0) ? longint'($urandom) : near_offset(lm, x + sx, y, sy, h);
      rq = ($urandom_range(5) == 0) ? longint'($urandom) : near_offset(rm, x + sx, y, sy, h);
      if ($urandom_range(9) == 0) begin
         rm = lm;
         rq = lq;
      end
      return make_record(r.state, r.flags, lm, lq, rm, rq, sx, sy, x, y, w, h);
   endfunction

   task automatic send_record(input edge_record_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_BITS'({r.h, r.w, r.y, r.x, r.sy, r.sx, r.rq, r.rm, r.lq,
                                   r.lm, r.flags});
      req_tuser <= r.state;
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_on_blank.push_back(roi_on_blank(r, image_width_model));
      states_sent[r.state]++;
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (pending_on_blank.size() != 0) @(posedge clock);
   endtask

   task automatic write_image_width(input logic [WIDTH_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      image_width_model = value;
      width_writes++;
   endtask

   task automatic test_fixed_states();
      send_record(make_record(ST_MATERIAL, 0, 65536, 0, -65536, 0, 0, 0, 100, 10, 20, 20));
      send_record(make_record(ST_BACKGROUND, 15, 0, 0, 0, 0, 0, 0, 100, 10, 20, 20));
      send_record(make_record(ST_UNKNOWN, 5, 0, 0, 0, 0, 0, 0, 600, -10, 20, 20));
      send_record(make_record(ST_INVALID, 10, 0, 0, 0, 0, 0, 0, 600, -10, 20, 20));
      // Other state uses the flat line through the frame row.
      send_record(make_record(ST_OTHER, 0, 65536, 1000, 0, 0, 0, 0, 100, 10, 10, 10));
      send_record(make_record(ST_OTHER, 0, 0, 0, 0, 0, 0, 20, 100, -30, 10, 5));
      send_record(make_record(ST_OTHER, 1, 0, 0, 0, 0, 0, 0, 100, 10, 10, 10));
      send_record(make_record(ST_OTHER, 1, 0, 0, 0, 0, 5, -5, 100, -30, 10, 10));
   endtask

   task automatic test_single_edges();
      send_record(make_record(ST_LEFT_EDGE, 3, 65536, 0, 0, 0, 0, 0, 600, 10, 50, 50));
      send_record(make_record(ST_LEFT_EDGE, 12, 65536, 0, 0, 0, 0, 0, 600, 10, 50, 50));
      send_record(make_record(ST_LEFT_EDGE, 0, 32768, 300 * ONE_PX, 0, 0, 0, 0,
                              100, 10, 50, 50));
      send_record(make_record(ST_LEFT_EDGE, 4, -32768, -50 * ONE_PX, 0, 0, 0, 0,
                              600, 10, 50, 50));
      send_record(make_record(ST_RIGHT_EDGE, 3, 0, 0, 65536, -100 * ONE_PX, 0, 0,
                              100, 10, 50, 50));
      send_record(make_record(ST_RIGHT_EDGE, 12, 0, 0, 65536, 0, 0, 0, 100, 10, 50, 50));
      send_record(make_record(ST_RIGHT_EDGE, 0, 0, 0, -65536, 800 * ONE_PX, 0, 0,
                              700, 10, 50, 50));
   endtask

   task automatic test_both_edges();
      send_record(make_record(ST_BOTH_EDGES, 0, 0, 200 * ONE_PX, 0, -200 * ONE_PX, 0, 0,
                              100, 10, 100, 100));
      send_record(make_record(ST_BOTH_EDGES, 0, 0, 200 * ONE_PX, 0, -200 * ONE_PX, 0, 0,
                              600, 10, 100, 100));
      send_record(make_record(ST_BOTH_EDGES, 0, 65536, 0, -65536, 900 * ONE_PX, 0, 0,
                              400, 300, 300, 100));
      send_record(make_record(ST_BOTH_EDGES, 1, 65536, 0, -65536, 900 * ONE_PX, 0, 0,
                              400, 300, 300, 100));
      // Identical lines: the tie keeps the left line.
      send_record(make_record(ST_BOTH_EDGES, 0, 16384, 40 * ONE_PX, 16384, 40 * ONE_PX,
                              0, 0, 450, 100, 100, 20));
      send_record(make_record(ST_BOTH_EDGES, 2, 0, 50 * ONE_PX, 0, 80 * ONE_PX, 0, 0,
                              412, 60, 100, 10));
      send_record(make_record(ST_BOTH_EDGES, 8, 0, 50 * ONE_PX, 0, 80 * ONE_PX, 0, 0,
                              512, 60, 100, 10));
   endtask

   task automatic test_field_extremes();
      send_record(make_record(ST_BOTH_EDGES, 15, SLOPE_MAX, OFFSET_MAX, SLOPE_MAX,
                              OFFSET_MAX, 32767, 32767, 32767, 32767, 32767, 32767));
      send_record(make_record(ST_LEFT_EDGE, 0, SLOPE_MIN, OFFSET_MIN, SLOPE_MIN,
                              OFFSET_MIN, -32768, -32768, -32768, -32768, 0, 0));
      send_record(make_record(ST_RIGHT_EDGE, 6, SLOPE_MAX, OFFSET_MIN, SLOPE_MIN,
                              OFFSET_MAX, 32767, -32768, -32768, 32767, 32767, 0));
   endtask

   task automatic test_random_records(input int count);
      repeat (count) send_record(random_record(image_width_model));
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tdata[0]) blank_results++;
         if (pending_on_blank.size() == 0) begin
            $error("on_blank: no word expected, actual %0d", rsp_tdata[0]);
            failures++;
         end else begin
            wanted_blank = pending_on_blank.pop_front();
            if (rsp_tdata[0] !== wanted_blank) begin
               $error("on_blank: expected %0d, actual %0d", wanted_blank, rsp_tdata[0]);
               failures++;
            end
         end
      end
   end

   // Ends a hung run: counts cycles in which neither stream moves a word.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("roi_edge_side_checker test failed");
         $finish;
      end
   end

   initial begin
      int covered_states;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 72;
      test_fixed_states();
      test_single_edges();
      test_both_edges();
      test_field_extremes();

      // The sender holds off here until the pipeline has emptied.
      wait_results_drained();
      write_image_width(16'd640);
      test_random_records(90);
      wait_results_drained();
      write_image_width(16'd1);
      test_random_records(90);

      send_idle_pct = 72;
      recv_idle_pct = 30;
      wait_results_drained();
      write_image_width(16'd65535);
      test_random_records(90);
      wait_results_drained();
      write_image_width(16'd0);
      test_random_records(90);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_results_drained();
      write_image_width(WIDTH_BITS'($urandom_range(65534, 2)));
      test_random_records(90);
      wait_results_drained();
      write_image_width(IMAGE_WIDTH_RESET);
      test_random_records(80);

      wait_results_drained();
      repeat (10) @(posedge clock);

      covered_states = 0;
      foreach (states_sent[i]) if (states_sent[i] != 0) covered_states++;
      $display("Checked %0d result words, %0d of them with the ROI on blank.",
               results_seen, blank_results);
      $display("Request words covered %0d of 8 image states under %0d image width writes.",
               covered_states, width_writes);
      if (failures == 0) begin
         $display("roi_edge_side_checker test passed");
      end else begin
         $display("roi_edge_side_checker test failed");
      end
      $finish;
   end

endmodule

### files.f
hdl/resc_pkg.sv
hdl/roi_edge_side_checker.sv
verif/testbench.sv
